FILE: hdl/pfi_pkg.sv
// Shared types and constants of the Pareto frontier insert block.
// No dependencies; compile first.
`default_nettype none

package pfi_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned RISK_W   = 32;
  localparam int unsigned RET_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIELD_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT    = 3'd0,
    ST_DOMINATED = 3'd1,
    ST_FULL      = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_SRCH,
    S_REM,
    S_PLAN,
    S_MOVE,
    S_EMIT,
    S_RD,
    S_RDD
  } state_e;

  typedef struct packed {
    logic [RISK_W-1:0] risk;
    logic [RET_W-1:0]  ret;
  } point_t;

endpackage

`default_nettype wire

FILE: hdl/pfi_intf.sv
// Request and result channel interfaces of the Pareto frontier insert block.
// Depends on pfi_pkg.
`default_nettype none

interface pfi_req_if;
  import pfi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [RISK_W-1:0]        point_risk;
  logic signed [RET_W-1:0]  point_return;

  modport source (output valid, kind, point_risk, point_return, input ready);
  modport sink   (input valid, kind, point_risk, point_return, output ready);
endinterface

interface pfi_rsp_if;
  import pfi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FIELD_W-1:0]       position;
  logic [FIELD_W-1:0]       removed_count;
  logic [FIELD_W-1:0]       entry_count;
  logic [RISK_W-1:0]        entry_risk;
  logic signed [RET_W-1:0]  entry_return;
  logic                     last;

  modport source (output valid, status, position, removed_count, entry_count,
                  entry_risk, entry_return, last, input ready);
  modport sink   (input valid, status, position, removed_count, entry_count,
                  entry_risk, entry_return, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/pfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/pareto_frontier_insert.sv
// Top level of the Pareto frontier insert block: sequencer, point table RAM
// and result register. Depends on pfi_pkg, pfi_intf (pfi_req_if, pfi_rsp_if)
// and pfi_ram.
//
//   Channel | Dir | Handshake     | Payload
//   --------+-----+---------------+----------------------------------------------
//   req_i   | in  | valid / ready | kind, point_risk, point_return
//   rsp_o   | out | valid / ready | status, position, removed_count, entry_count,
//           |     |               | entry_risk, entry_return, last
//
// One request at a time. The single read port and single write port of the point
// RAM walk the table one entry a cycle in the search and the shift; a read of
// the table passes each entry through S_RD and S_RDD and stalls on the result.
// Reset clears the entry count and the control state; the RAM needs no clearing pass.
// A stalled result sits in the output register; the next request is still
// taken, and its result waits until the register drains.
`default_nettype none

module pareto_frontier_insert #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfi_req_if.sink    req_i,
  pfi_rsp_if.source  rsp_o
);
  import pfi_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PtW   = $bits(point_t);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [CntW-1:0] One    = CntW'(1);

  // Sequencer state
  state_e state_q, state_d;

  // Table occupancy and the point under work
  logic [CntW-1:0] cnt_q, cnt_d;
  point_t          pt_q, pt_d;

  // Walk index, insert index, removal count, previous return
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         p_q, p_d;
  logic [CntW-1:0]         r_q, r_d;
  logic signed [RET_W-1:0] prev_ret_q, prev_ret_d;

  // Shift engine: moves left, next source, pending read and its source
  logic [CntW-1:0] mv_left_q, mv_left_d;
  logic [CntW-1:0] mv_src_q, mv_src_d;
  logic            mv_pend_q, mv_pend_d;
  logic [CntW-1:0] mv_psrc_q, mv_psrc_d;

  // Result of an offer, clear or empty read, waiting for the output register
  status_e         res_status_q, res_status_d;
  logic [CntW-1:0] res_pos_q, res_pos_d;
  logic [CntW-1:0] res_rem_q, res_rem_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [FIELD_W-1:0]      out_pos_q, out_pos_d;
  logic [FIELD_W-1:0]      out_rem_q, out_rem_d;
  logic [FIELD_W-1:0]      out_cnt_q, out_cnt_d;
  logic [RISK_W-1:0]       out_risk_q, out_risk_d;
  logic signed [RET_W-1:0] out_ret_q, out_ret_d;
  logic                    out_last_q, out_last_d;

  // RAM port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  point_t           ram_wdata;
  logic [PtW-1:0]   ram_rdata;
  point_t           rd_pt;

  // Shared decisions
  logic                    req_fire;
  kind_e                   req_kind;
  logic signed [RET_W-1:0] pt_ret, rd_ret;
  logic                    beyond, ret_le, ret_lt, ret_gt, prev_beats;
  logic                    found, at_end, has_next, rd_last;
  logic                    out_free, full_plan, mv_done;
  logic [CntW-1:0]         idx_inc, cnt_dec, mv_dst;

  pfi_ram #(
    .WIDTH (PtW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_pt = point_t'(ram_rdata);

  always_comb begin
    req_fire   = req_i.valid && req_i.ready;
    req_kind   = kind_e'(req_i.kind);
    pt_ret     = $signed(pt_q.ret);
    rd_ret     = $signed(rd_pt.ret);
    beyond     = pt_q.risk > rd_pt.risk;
    found      = pt_q.risk < rd_pt.risk;
    ret_le     = pt_ret <= rd_ret;
    ret_lt     = pt_ret < rd_ret;
    ret_gt     = pt_ret > rd_ret;
    prev_beats = pt_ret < prev_ret_q;
    idx_inc    = idx_q + One;
    cnt_dec    = cnt_q - One;
    at_end     = idx_q == cnt_dec;
    has_next   = idx_inc < cnt_q;
    rd_last    = idx_inc == cnt_q;
    out_free   = !out_valid_q || rsp_o.ready;
    full_plan  = (r_q == '0) && (cnt_q == CapCnt);
    mv_done    = (mv_left_q == '0) && !mv_pend_q;
    // Shift up by one when nothing is removed, else down by r - 1
    mv_dst     = mv_psrc_q + One - r_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (req_kind)
            KIND_OFFER: state_d = (cnt_q == '0) ? S_EMIT : S_LAST;
            KIND_READ:  state_d = (cnt_q == '0) ? S_EMIT : S_RD;
            KIND_CLEAR: state_d = S_EMIT;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LAST: begin
        state_d = beyond ? S_EMIT : S_SRCH;
      end
      S_SRCH: begin
        if (found) begin
          if (idx_q != '0 && prev_beats) begin
            state_d = S_EMIT;
          end else if (ret_gt && has_next) begin
            state_d = S_REM;
          end else begin
            state_d = S_PLAN;
          end
        end else if (at_end) begin
          state_d = ret_lt ? S_EMIT : S_PLAN;
        end
      end
      S_REM: begin
        if (!(ret_gt && has_next)) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        state_d = full_plan ? S_EMIT : S_MOVE;
      end
      S_MOVE: begin
        if (mv_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          state_d = S_RDD;
        end
      end
      S_RDD: begin
        state_d = rd_last ? S_IDLE : S_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM port and output register control
  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    cnt_d        = cnt_q;
    pt_d         = pt_q;
    idx_d        = idx_q;
    p_d          = p_q;
    r_d          = r_q;
    prev_ret_d   = prev_ret_q;
    mv_left_d    = mv_left_q;
    mv_src_d     = mv_src_q;
    mv_pend_d    = mv_pend_q;
    mv_psrc_d    = mv_psrc_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_rem_d    = res_rem_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = pt_q;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_rem_d    = out_rem_q;
    out_cnt_d    = out_cnt_q;
    out_risk_d   = out_risk_q;
    out_ret_d    = out_ret_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          pt_d      = '{risk: req_i.point_risk, ret: req_i.point_return};
          res_pos_d = '0;
          res_rem_d = '0;
          idx_d     = '0;
          case (req_kind)
            KIND_OFFER: begin
              if (cnt_q == '0) begin
                // Empty table: take the point at the head
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = '{risk: req_i.point_risk, ret: req_i.point_return};
                cnt_d        = One;
                res_status_d = ST_ACCEPT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_dec[AddrW-1:0];
              end
            end
            KIND_READ: begin
              res_status_d = ST_EMPTY;
            end
            KIND_CLEAR: begin
              cnt_d        = '0;
              res_status_d = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end

      S_LAST: begin
        // Entry n-1 is on the read port
        res_pos_d = cnt_q;
        if (beyond) begin
          if (ret_le) begin
            res_status_d = ST_DOMINATED;
          end else if (cnt_q == CapCnt) begin
            res_status_d = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = cnt_q[AddrW-1:0];
            cnt_d        = cnt_q + One;
            res_status_d = ST_ACCEPT;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end

      S_SRCH: begin
        // Entry idx is on the read port; scan for the first greater risk
        if (found) begin
          p_d       = idx_q;
          res_pos_d = idx_q;
          r_d       = '0;
          if (idx_q != '0 && prev_beats) begin
            res_status_d = ST_DOMINATED;
          end else if (ret_gt) begin
            r_d = One;
            if (has_next) begin
              ram_re    = 1'b1;
              ram_raddr = idx_inc[AddrW-1:0];
              idx_d     = idx_inc;
            end
          end
        end else if (at_end) begin
          // Equal to the last risk: go after it
          p_d          = cnt_q;
          r_d          = '0;
          res_pos_d    = cnt_q;
          res_status_d = ST_DOMINATED;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = idx_inc[AddrW-1:0];
          idx_d      = idx_inc;
          prev_ret_d = rd_ret;
        end
      end

      S_REM: begin
        // Count dominated entries from the insert index on
        if (ret_gt) begin
          r_d = r_q + One;
          if (has_next) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AddrW-1:0];
            idx_d     = idx_inc;
          end
        end
      end

      S_PLAN: begin
        res_pos_d = p_q;
        mv_pend_d = 1'b0;
        if (full_plan) begin
          res_status_d = ST_FULL;
          res_rem_d    = '0;
        end else if (r_q == '0) begin
          // Open a slot: move p..n-1 up by one, top first
          mv_left_d = cnt_q - p_q;
          mv_src_d  = cnt_dec;
        end else if (r_q == One) begin
          mv_left_d = '0;
          mv_src_d  = p_q;
        end else begin
          // Close the gap: move p+r..n-1 down by r-1, bottom first
          mv_left_d = cnt_q - p_q - r_q;
          mv_src_d  = p_q + r_q;
        end
      end

      S_MOVE: begin
        if (mv_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = mv_dst[AddrW-1:0];
          ram_wdata = rd_pt;
        end
        if (mv_left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = mv_src_q[AddrW-1:0];
          mv_pend_d = 1'b1;
          mv_psrc_d = mv_src_q;
          mv_src_d  = (r_q == '0) ? mv_src_q - One : mv_src_q + One;
          mv_left_d = mv_left_q - One;
        end else begin
          mv_pend_d = 1'b0;
        end
        if (mv_done) begin
          // Drop the point into its slot
          ram_we       = 1'b1;
          ram_waddr    = p_q[AddrW-1:0];
          ram_wdata    = pt_q;
          cnt_d        = cnt_q - r_q + One;
          res_status_d = ST_ACCEPT;
          res_pos_d    = p_q;
          res_rem_d    = r_q;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = FIELD_W'(res_pos_q);
          out_rem_d    = FIELD_W'(res_rem_q);
          out_cnt_d    = FIELD_W'(cnt_q);
          out_risk_d   = '0;
          out_ret_d    = '0;
          out_last_d   = 1'b1;
        end
      end

      S_RD: begin
        if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AddrW-1:0];
        end
      end

      S_RDD: begin
        // Output register drained in S_RD; load the entry
        out_load     = 1'b1;
        out_status_d = ST_ENTRY;
        out_pos_d    = FIELD_W'(idx_q);
        out_rem_d    = '0;
        out_cnt_d    = FIELD_W'(cnt_q);
        out_risk_d   = rd_pt.risk;
        out_ret_d    = rd_ret;
        out_last_d   = rd_last;
        idx_d        = idx_inc;
      end

      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mv_pend_q   <= 1'b0;
      mv_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mv_pend_q   <= mv_pend_d;
      mv_left_q   <= mv_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pt_q         <= pt_d;
    idx_q        <= idx_d;
    p_q          <= p_d;
    r_q          <= r_d;
    prev_ret_q   <= prev_ret_d;
    mv_src_q     <= mv_src_d;
    mv_psrc_q    <= mv_psrc_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_rem_q    <= res_rem_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_rem_q    <= out_rem_d;
    out_cnt_q    <= out_cnt_d;
    out_risk_q   <= out_risk_d;
    out_ret_q    <= out_ret_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.position      = out_pos_q;
  assign rsp_o.removed_count = out_rem_q;
  assign rsp_o.entry_count   = out_cnt_q;
  assign rsp_o.entry_risk    = out_risk_q;
  assign rsp_o.entry_return  = out_ret_q;
  assign rsp_o.last          = out_last_q;

  // The table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("entry count above capacity");

  // The RAM is never read and written at the same entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten");

  // A clear empties the table at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.kind == KIND_CLEAR) |=> (cnt_q == '0))
    else $error("clear left entries behind");

endmodule

`default_nettype wire

FILE: tb/pareto_frontier_insert_tb.sv
// Self-checking testbench for pareto_frontier_insert: random and directed offer, read
// and clear requests, with results checked against an in-bench frontier predictor.
// Depends on pfi_pkg, pfi_intf (pfi_req_if, pfi_rsp_if) and the block's RTL.
module pareto_frontier_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfi_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 230;
  localparam int unsigned TAIL_ITEMS   = 30;    // no idling once this few are left
  localparam int unsigned HOLD_AFTER   = 60;    // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [RISK_W-1:0] risk;
    logic [RET_W-1:0]  ret;
  } point_request_t;

  typedef struct {
    status_e            status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] removed;
    logic [FIELD_W-1:0] count;
    logic [RISK_W-1:0]  risk;
    logic [RET_W-1:0]   ret;
    logic               last;
  } frontier_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfi_req_if req_bus ();
  pfi_rsp_if rsp_bus ();

  pareto_frontier_insert #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Requests still to be sent and results still owed by the block.
  point_request_t   pending_requests[$];
  frontier_result_t expected_results[$];

  // Predicted frontier: rising risk, rising return.
  logic [RISK_W-1:0]       front_risk [CAPACITY];
  logic signed [RET_W-1:0] front_ret  [CAPACITY];
  int unsigned             front_len;

  int unsigned mismatches;
  int unsigned unexpected;
  int unsigned counted_items;
  int unsigned results_seen;

  // Pacing state.
  logic [7:0]  mode_timer;
  logic        src_bursty, snk_bursty;
  logic        calm_tail;
  logic [3:0]  src_gap, snk_gap;
  int unsigned hold_left;
  logic        hold_done;
  wire         hold_active = (hold_left != 0);

  point_request_t next_req;

  // Bounds of the last rising run, used to aim insertions into its middle.
  logic [RISK_W-1:0] run_risk_lo, run_risk_hi;
  logic [RET_W-1:0]  run_ret_lo, run_ret_hi;

  // ---------------------------------------------------------------------------
  // Frontier predictor
  // ---------------------------------------------------------------------------

  // Queue one expected result; entry_count is the table size after the request.
  task automatic owe_result(input status_e st, input int unsigned pos,
                            input int unsigned removed, input logic [RISK_W-1:0] risk,
                            input logic [RET_W-1:0] ret, input logic last);
    frontier_result_t res;
    res.status   = st;
    res.position = FIELD_W'(pos);
    res.removed  = FIELD_W'(removed);
    res.count    = FIELD_W'(front_len);
    res.risk     = risk;
    res.ret      = ret;
    res.last     = last;
    expected_results.insert(expected_results.size(), res);
  endtask

  // Apply one accepted request to the predicted frontier and queue its results.
  task automatic update_frontier(input logic [KIND_W-1:0] kind,
                                 input logic [RISK_W-1:0] risk,
                                 input logic signed [RET_W-1:0] ret);
    int unsigned n, p, r, k;
    logic [RISK_W-1:0]       keep_risk [CAPACITY];
    logic signed [RET_W-1:0] keep_ret  [CAPACITY];
    n = front_len;
    case (kind)
      KIND_OFFER: begin
        if (n == 0) begin
          front_risk[0] = risk;
          front_ret[0]  = ret;
          front_len     = 1;
          owe_result(ST_ACCEPT, 0, 0, '0, '0, 1'b1);
        end else if (risk > front_risk[n-1]) begin
          // Beyond the riskiest entry: append only on a strictly better return.
          if (ret <= front_ret[n-1]) begin
            owe_result(ST_DOMINATED, n, 0, '0, '0, 1'b1);
          end else if (n >= CAPACITY) begin
            owe_result(ST_FULL, n, 0, '0, '0, 1'b1);
          end else begin
            front_risk[n] = risk;
            front_ret[n]  = ret;
            front_len     = n + 1;
            owe_result(ST_ACCEPT, n, 0, '0, '0, 1'b1);
          end
        end else begin
          // Insert after every entry of equal or lower risk.
          p = n;
          for (k = 0; k < n && p == n; k++) begin
            if (risk < front_risk[k]) p = k;
          end
          if (p > 0 && ret < front_ret[p-1]) begin
            owe_result(ST_DOMINATED, p, 0, '0, '0, 1'b1);
          end else begin
            r = 0;
            while (p + r < n && ret > front_ret[p+r]) r++;
            if (n - r >= CAPACITY) begin
              owe_result(ST_FULL, p, 0, '0, '0, 1'b1);
            end else begin
              keep_risk = front_risk;
              keep_ret  = front_ret;
              for (k = p + r; k < n; k++) begin
                front_risk[k-r+1] = keep_risk[k];
                front_ret[k-r+1]  = keep_ret[k];
              end
              front_risk[p] = risk;
              front_ret[p]  = ret;
              front_len     = n - r + 1;
              owe_result(ST_ACCEPT, p, r, '0, '0, 1'b1);
            end
          end
        end
      end
      KIND_READ: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, 0, 0, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < n; k++) begin
            owe_result(ST_ENTRY, k, 0, front_risk[k], front_ret[k], k + 1 == n);
          end
        end
      end
      KIND_CLEAR: begin
        front_len = 0;
        owe_result(ST_CLEARED, 0, 0, '0, '0, 1'b1);
      end
      default: ;  // unused kind: the block ignores it
    endcase
  endtask

  // Compare one result from the block with the oldest expectation.
  task automatic check_result();
    frontier_result_t want;
    if (expected_results.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= MAX_REPORTS)
        $display("[%0t] result with nothing expected: status %0d pos %0d", $realtime,
                 rsp_bus.status, rsp_bus.position);
    end else begin
      want = expected_results.pop_front();
      if (rsp_bus.status !== want.status || rsp_bus.position !== want.position ||
          rsp_bus.removed_count !== want.removed || rsp_bus.entry_count !== want.count ||
          rsp_bus.entry_risk !== want.risk || rsp_bus.entry_return !== want.ret ||
          rsp_bus.last !== want.last) begin
        mismatches++;
        if (mismatches + unexpected <= MAX_REPORTS) begin
          $display("[%0t] mismatch", $realtime);
          $display("  expected st %0d pos %0d rm %0d cnt %0d risk %h ret %h last %b",
                   want.status, want.position, want.removed, want.count,
                   want.risk, want.ret, want.last);
          $display("  actual   st %0d pos %0d rm %0d cnt %0d risk %h ret %h last %b",
                   rsp_bus.status, rsp_bus.position, rsp_bus.removed_count,
                   rsp_bus.entry_count, rsp_bus.entry_risk, rsp_bus.entry_return,
                   rsp_bus.last);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [RISK_W-1:0] risk,
                               input logic [RET_W-1:0] ret);
    point_request_t req;
    req.kind = kind;
    req.risk = risk;
    req.ret  = ret;
    pending_requests.insert(pending_requests.size(), req);
    if (kind != KIND_UNUSED) counted_items++;
  endtask

  // Rising run of offers: mostly strict improvements, so the table grows,
  // with the odd equal step to hit equal risk and equal return.
  task automatic queue_rising_run(input int unsigned len);
    logic [RISK_W-1:0] risk;
    logic [RET_W-1:0]  ret;
    int unsigned       k;
    risk = $urandom_range(0, 32'h00FF_FFFF);
    ret  = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
    run_risk_lo = risk;
    run_ret_lo  = ret;
    for (k = 0; k < len; k++) begin
      queue_request(KIND_OFFER, risk, ret);
      risk += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32'h4_0000);
      ret  += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32'h8_0000);
    end
    run_risk_hi = risk;
    run_ret_hi  = ret;
  endtask

  // Offers aimed inside the last run: inserts, removals, rejections and, on a
  // full table, overflow.
  task automatic queue_run_inserts(input int unsigned cnt);
    int unsigned k;
    for (k = 0; k < cnt; k++) begin
      queue_request(KIND_OFFER,
                    run_risk_lo + $urandom_range(0, run_risk_hi - run_risk_lo),
                    run_ret_lo - 32'h1_0000 +
                    $urandom_range(0, run_ret_hi - run_ret_lo + 32'h2_0000));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: send the next pending request, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_OFFER;
      req_bus.point_risk   <= '0;
      req_bus.point_return <= '0;
      src_gap              <= '0;
      calm_tail            <= 1'b0;
    end else begin
      calm_tail <= (pending_requests.size() < TAIL_ITEMS);
      // Predict at the acceptance edge so expectations keep request order.
      if (req_bus.valid && req_bus.ready)
        update_frontier(req_bus.kind, req_bus.point_risk, req_bus.point_return);
      if (!req_bus.valid || req_bus.ready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1'b1;
          req_bus.valid <= 1'b0;
        end else if (src_bursty && !calm_tail && !hold_active &&
                     $urandom_range(0, 4) == 0) begin
          src_gap       <= 4'($urandom_range(0, 8));
          req_bus.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req              = pending_requests.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.kind         <= next_req.kind;
          req_bus.point_risk   <= next_req.risk;
          req_bus.point_return <= next_req.ret;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check every accepted result, stall in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      snk_gap       <= '0;
      results_seen  <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        check_result();
        results_seen <= results_seen + 1;
      end
      if (hold_active) begin
        rsp_bus.ready <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap       <= snk_gap - 1'b1;
        rsp_bus.ready <= 1'b0;
      end else if (snk_bursty && !calm_tail && $urandom_range(0, 5) == 0) begin
        snk_gap       <= 4'($urandom_range(0, 8));
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Hold off the result channel once for a long stretch while requests keep
  // coming, so the output register fills and the block stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Switch idling on and off per side each time the 8-bit mode timer wraps, leaving calm stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_timer <= '0;
      src_bursty <= 1'b0;
      snk_bursty <= 1'b0;
    end else begin
      mode_timer <= mode_timer + 1'b1;
      if (mode_timer == '0) begin
        src_bursty <= ($urandom_range(0, 3) != 0);
        snk_bursty <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog: a hang or lost result ends the run here.
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned seg, k, goal;
    req_bus.valid        = 1'b0;
    req_bus.kind         = KIND_OFFER;
    req_bus.point_risk   = '0;
    req_bus.point_return = '0;
    rsp_bus.ready        = 1'b0;
    rst_ni               = 1'b0;
    front_len            = 0;
    mismatches           = 0;
    unexpected           = 0;
    counted_items        = 0;

    // Directed: empty table, ignored kind, each offer outcome, extremes.
    queue_request(KIND_READ, '0, '0);                        // read of empty table
    queue_request(KIND_CLEAR, '0, '0);                       // clear of empty table
    queue_request(KIND_UNUSED, '1, '1);                      // ignored, no result
    queue_request(KIND_OFFER, 32'h0001_0000, 32'h0000_0000); // first point
    queue_request(KIND_OFFER, 32'h0002_0000, 32'h0001_0000); // append
    queue_request(KIND_OFFER, 32'h0003_0000, 32'h0001_0000); // beyond, equal return
    queue_request(KIND_OFFER, 32'h0001_8000, 32'hFFFF_F000); // below lower neighbor
    queue_request(KIND_OFFER, 32'h0001_0000, 32'h0000_8000); // equal risk goes after
    queue_request(KIND_OFFER, 32'h0001_4000, 32'h0001_8000); // insert, drop one
    queue_request(KIND_OFFER, 32'h0000_0000, 32'h7FFF_FFFF); // drop the whole table
    queue_request(KIND_READ, '0, '0);
    queue_request(KIND_CLEAR, '0, '0);
    queue_request(KIND_OFFER, 32'hFFFF_FFFF, 32'h8000_0000); // max risk, min return
    queue_request(KIND_OFFER, 32'h0000_0000, 32'h8000_0000); // insert at front
    queue_request(KIND_OFFER, 32'hFFFF_FFFF, 32'h7FFF_FFFF); // equal max risk
    queue_request(KIND_READ, '0, '0);
    queue_request(KIND_CLEAR, '0, '0);

    // Random: first a run long enough to fill the table and overflow it.
    goal = counted_items + RANDOM_ITEMS;
    queue_rising_run(36);
    queue_run_inserts(3);
    queue_request(KIND_READ, '0, '0);
    while (counted_items < goal) begin
      seg = $urandom_range(0, 99);
      if (seg < 35) begin
        if ($urandom_range(0, 1) == 0) queue_request(KIND_CLEAR, $urandom, $urandom);
        queue_rising_run($urandom_range(4, 40));
        if ($urandom_range(0, 1) == 0) queue_request(KIND_READ, $urandom, $urandom);
      end else if (seg < 65) begin
        queue_run_inserts($urandom_range(1, 8));
      end else if (seg < 78) begin
        for (k = $urandom_range(1, 4); k != 0; k--)
          queue_request(KIND_OFFER, $urandom, $urandom);
      end else if (seg < 88) begin
        queue_request(KIND_READ, $urandom, $urandom);
      end else if (seg < 94) begin
        queue_request(KIND_CLEAR, $urandom, $urandom);
      end else begin
        queue_request(KIND_UNUSED, $urandom, $urandom);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for every request to go out, then for every owed result.
    while (pending_requests.size() != 0 || req_bus.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
